// ----- rtl/core/ggfa_pkg.sv -----
// ----------------------------------------------------------------------------
// ggfa_pkg
// Shared types and constants of the GBK glyph flash address block.
// ----------------------------------------------------------------------------
package ggfa_pkg;

   typedef enum logic [1:0] {
      ACT_READ = 2'd0,
      ACT_FILL = 2'd1,
      ACT_NONE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_BASE_SMALL  = 2'd0,
      CSR_BASE_MEDIUM = 2'd1,
      CSR_BASE_LARGE  = 2'd2
   } csr_index_type;

   localparam int unsigned BASE_W = 24;
   localparam int unsigned ADDR_W = 32;

   localparam logic [7:0] HEIGHT_SMALL  = 8'd12;
   localparam logic [7:0] HEIGHT_MEDIUM = 8'd16;
   localparam logic [7:0] HEIGHT_LARGE  = 8'd24;

   localparam logic [7:0] BYTES_SMALL  = 8'd24;
   localparam logic [7:0] BYTES_MEDIUM = 8'd32;
   localparam logic [7:0] BYTES_LARGE  = 8'd72;

   localparam logic [BASE_W-1:0] BASE_SMALL_RST  = 24'h093D0E;
   localparam logic [BASE_W-1:0] BASE_MEDIUM_RST = 24'h114FDE;
   localparam logic [BASE_W-1:0] BASE_LARGE_RST  = 24'h1F43DE;

   localparam logic [7:0] TRAIL_GAP = 8'h7F;

   localparam logic [ADDR_W-1:0] OFS_GBK5   = 32'd846;
   localparam logic [ADDR_W-1:0] OFS_HANZI  = 32'd1038;
   localparam logic [ADDR_W-1:0] OFS_GBK3   = 32'd6768;
   localparam logic [ADDR_W-1:0] OFS_GBK4   = 32'd12848;
   localparam logic [ADDR_W-1:0] OFS_FOUR   = 32'd21008;
   localparam logic [ADDR_W-1:0] OFS_FOUR_B = 32'd161;

   typedef struct packed {
      logic [7:0] font_height;
      logic [7:0] fourth_byte;
      logic [7:0] third_byte;
      logic [7:0] second_byte;
      logic [7:0] lead_byte;
   } char_type;

endpackage

// ----- rtl/core/gbk_glyph_flash_address.sv -----
// ----------------------------------------------------------------------------
// gbk_glyph_flash_address
// Font-ROM byte address and read length of a GBK / GB18030 glyph.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: lead, second, third, fourth, height
//   rsp      out  rsp_tvalid/rsp_tready  tdata: rom_address, byte_count; tuser: action
//   csr      in   csr_we                 csr_index, csr_wdata (table bases)
//
// One beat per cycle while rsp_tready is high; a request beat passes the input
// register, the index and address logic and the result register before
// rsp_tvalid rises.
// Reset loads the three table bases and empties both stages.
// A stalled result holds; the input register still takes one more beat.
// ----------------------------------------------------------------------------
module gbk_glyph_flash_address import ggfa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // lead, second, third, fourth, font_height
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // rom_address[31:0], byte_count[39:32]
   output logic [1:0]        rsp_tuser,   // action
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [BASE_W-1:0] csr_wdata
);

   logic [BASE_W-1:0] base_small_ff, base_medium_ff, base_large_ff;
   char_type          chr_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   action_type        action_ff, action_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        count_ff, count_in;
   logic              advance;
   logic              req_take;
   logic [ADDR_W-1:0] glyph_index;
   logic [ADDR_W-1:0] scaled;
   logic [BASE_W-1:0] base_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_small_ff  <= BASE_SMALL_RST;
         base_medium_ff <= BASE_MEDIUM_RST;
         base_large_ff  <= BASE_LARGE_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_SMALL:  base_small_ff  <= csr_wdata;
            CSR_BASE_MEDIUM: base_medium_ff <= csr_wdata;
            CSR_BASE_LARGE:  base_large_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         chr_ff <= char_type'(req_tdata);
      end
   end

   ggfa_index u_index (
      .chr         (chr_ff),
      .glyph_index (glyph_index)
   );

   always_comb begin
      action_in = ACT_READ;
      addr_in   = '0;
      count_in  = '0;
      scaled    = '0;
      base_sel  = '0;
      case (chr_ff.font_height)
         HEIGHT_SMALL: begin
            count_in = BYTES_SMALL;
            scaled   = (glyph_index << 4) + (glyph_index << 3);
            base_sel = base_small_ff;
         end
         HEIGHT_MEDIUM: begin
            count_in = BYTES_MEDIUM;
            scaled   = glyph_index << 5;
            base_sel = base_medium_ff;
         end
         HEIGHT_LARGE: begin
            count_in = BYTES_LARGE;
            scaled   = (glyph_index << 6) + (glyph_index << 3);
            base_sel = base_large_ff;
         end
         default: begin
            action_in = ACT_NONE;
         end
      endcase
      if (action_in == ACT_READ) begin
         if (chr_ff.second_byte == TRAIL_GAP) begin
            action_in = ACT_FILL;
         end else begin
            addr_in = scaled + {8'd0, base_sel};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff <= action_in;
         addr_ff   <= addr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {count_ff, addr_ff};
   assign rsp_tuser  = action_ff;

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && action_ff == ACT_NONE |-> addr_ff == '0 && count_ff == '0)
      else $error("no-action result carries data");

   a_fill_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && action_ff == ACT_FILL |-> addr_ff == '0)
      else $error("fill result carries an address");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && action_ff != ACT_NONE |->
      count_ff == BYTES_SMALL || count_ff == BYTES_MEDIUM || count_ff == BYTES_LARGE)
      else $error("glyph byte count out of set");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted beat lost in input register");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat lost in result register");

endmodule

// ----- rtl/core/ggfa_index.sv -----
// ----------------------------------------------------------------------------
// ggfa_index
// Glyph index of one character by GBK / GB18030 region, 32-bit wrap.
// ----------------------------------------------------------------------------
module ggfa_index import ggfa_pkg::*; (
   input  char_type          chr,
   output logic [ADDR_W-1:0] glyph_index
);

   logic [7:0]        sym_lo;
   logic [7:0]        sym_hi;
   logic [7:0]        c1;
   logic [7:0]        c2;
   logic [7:0]        c2_adj;
   logic [ADDR_W-1:0] z1;
   logic [ADDR_W-1:0] z2;
   logic [ADDR_W-1:0] z3;
   logic [ADDR_W-1:0] z4;
   logic [ADDR_W-1:0] za;
   logic [ADDR_W-1:0] h_first;
   logic              not_small;

   assign c1        = chr.lead_byte;
   assign c2        = chr.second_byte;
   assign c2_adj    = (c2 > TRAIL_GAP) ? c2 - 8'd1 : c2;
   assign z1        = {24'd0, c1};
   assign z2        = {24'd0, c2};
   assign z3        = {24'd0, chr.third_byte};
   assign z4        = {24'd0, chr.fourth_byte};
   assign za        = {24'd0, c2_adj};
   assign not_small = (chr.font_height != HEIGHT_SMALL);

   always_comb begin
      case (chr.font_height)
         HEIGHT_SMALL: begin
            sym_lo = 8'hA1;
            sym_hi = 8'hA9;
         end
         HEIGHT_MEDIUM: begin
            sym_lo = 8'hA0;
            sym_hi = 8'hA1;
         end
         default: begin
            sym_lo = 8'hA1;
            sym_hi = 8'hAB;
         end
      endcase
   end

   always_comb begin
      if (c1 >= sym_lo && c1 <= sym_hi && c2 >= 8'hA1) begin
         h_first = (z1 - 32'hA1) * 32'd94 + (z2 - 32'hA1);
      end else if (c1 >= 8'hA8 && c1 <= 8'hA9 && c2 < 8'hA1) begin
         h_first = (z1 - 32'hA8) * 32'd96 + (za - 32'h40) + OFS_GBK5;
      end else begin
         h_first = '0;
      end

      if (c1 >= 8'hB0 && c1 <= 8'hF7 && c2 >= 8'hA1) begin
         glyph_index = (z1 - 32'hB0) * 32'd94 + (z2 - 32'hA1) + OFS_HANZI;
      end else if (c1 < 8'hA1 && c1 >= 8'h81 && c2 >= 8'h40) begin
         glyph_index = (z1 - 32'h81) * 32'd190 + (za - 32'h40) + OFS_HANZI + OFS_GBK3;
      end else if (c1 >= 8'hAA && c2 < 8'hA1) begin
         glyph_index = (z1 - 32'hAA) * 32'd96 + (za - 32'h40) + OFS_HANZI + OFS_GBK4;
      end else if (not_small && c1 == 8'h81 && c2 >= 8'h39) begin
         glyph_index = OFS_HANZI + OFS_FOUR + (z3 - 32'hEE) * 32'd10 + z4 - 32'h39;
      end else if (not_small && c1 == 8'h82) begin
         glyph_index = OFS_HANZI + OFS_FOUR + OFS_FOUR_B + (z2 - 32'h30) * 32'd1260
                       + (z3 - 32'h81) * 32'd10 + z4 - 32'h30;
      end else begin
         glyph_index = h_first;
      end
   end

endmodule

// ----- tb/sv/glyph_address_check.sv -----
// ----------------------------------------------------------------------------
// glyph_address_check
// Watches the request, result and register ports of the GBK glyph address
// block, predicts the ROM read of every accepted character from its own copy
// of the table bases, and compares each result beat with the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module glyph_address_check import ggfa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [39:0]       req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [39:0]       rsp_tdata,
   input  logic [1:0]        rsp_tuser,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [BASE_W-1:0] csr_wdata,
   output int                errors,
   output int                open_count
);

   typedef struct {
      action_type act;
      bit [31:0]  addr;
      bit [7:0]   count;
   } glyph_read_type;

   glyph_read_type    pending_reads[$];
   bit [BASE_W-1:0]   table_small;
   bit [BASE_W-1:0]   table_medium;
   bit [BASE_W-1:0]   table_large;

   function automatic bit [31:0] trail_drop(bit [31:0] c2);
      return (c2 > 32'h7F) ? c2 - 32'd1 : c2;
   endfunction

   // glyph number of a character, 32-bit wrap throughout
   function automatic bit [31:0] glyph_slot(bit [31:0] c1, bit [31:0] c2, bit [31:0] c3,
                                            bit [31:0] c4, bit [7:0] hgt);
      bit [31:0] slot;
      bit [31:0] sym_lo;
      bit [31:0] sym_hi;
      slot = 32'd0;
      if (hgt == HEIGHT_SMALL) begin
         sym_lo = 32'hA1;
         sym_hi = 32'hA9;
      end else if (hgt == HEIGHT_MEDIUM) begin
         sym_lo = 32'hA0;
         sym_hi = 32'hA1;
      end else begin
         sym_lo = 32'hA1;
         sym_hi = 32'hAB;
      end

      if (c1 >= sym_lo && c1 <= sym_hi && c2 >= 32'hA1) begin
         slot = (c1 - 32'hA1) * 32'd94 + (c2 - 32'hA1);
      end else if (c1 >= 32'hA8 && c1 <= 32'hA9 && c2 < 32'hA1) begin
         c2 = trail_drop(c2);
         slot = (c1 - 32'hA8) * 32'd96 + (c2 - 32'h40) + OFS_GBK5;
      end

      if (c1 >= 32'hB0 && c1 <= 32'hF7 && c2 >= 32'hA1) begin
         slot = (c1 - 32'hB0) * 32'd94 + (c2 - 32'hA1) + OFS_HANZI;
      end else if (c1 < 32'hA1 && c1 >= 32'h81 && c2 >= 32'h40) begin
         c2 = trail_drop(c2);
         slot = (c1 - 32'h81) * 32'd190 + (c2 - 32'h40) + OFS_HANZI + OFS_GBK3;
      end else if (c1 >= 32'hAA && c2 < 32'hA1) begin
         c2 = trail_drop(c2);
         slot = (c1 - 32'hAA) * 32'd96 + (c2 - 32'h40) + OFS_HANZI + OFS_GBK4;
      end else if (hgt != HEIGHT_SMALL && c1 == 32'h81 && c2 >= 32'h39) begin
         slot = OFS_HANZI + OFS_FOUR + (c3 - 32'hEE) * 32'd10 + c4 - 32'h39;
      end else if (hgt != HEIGHT_SMALL && c1 == 32'h82) begin
         slot = OFS_HANZI + OFS_FOUR + OFS_FOUR_B + (c2 - 32'h30) * 32'd1260
                + (c3 - 32'h81) * 32'd10 + c4 - 32'h30;
      end
      return slot;
   endfunction

   function automatic glyph_read_type predict_glyph_read(char_type ch);
      glyph_read_type rd;
      bit [31:0]      base;
      rd.act   = ACT_READ;
      rd.addr  = 32'd0;
      rd.count = 8'd0;
      if (ch.font_height == HEIGHT_SMALL) begin
         rd.count = BYTES_SMALL;
         base = {8'd0, table_small};
      end else if (ch.font_height == HEIGHT_MEDIUM) begin
         rd.count = BYTES_MEDIUM;
         base = {8'd0, table_medium};
      end else if (ch.font_height == HEIGHT_LARGE) begin
         rd.count = BYTES_LARGE;
         base = {8'd0, table_large};
      end else begin
         rd.act = ACT_NONE;
         return rd;
      end
      if (ch.second_byte == TRAIL_GAP) begin
         rd.act = ACT_FILL;
         return rd;
      end
      rd.addr = glyph_slot({24'd0, ch.lead_byte}, {24'd0, ch.second_byte},
                           {24'd0, ch.third_byte}, {24'd0, ch.fourth_byte},
                           ch.font_height) * {24'd0, rd.count} + base;
      return rd;
   endfunction

   initial begin
      errors = 0;
      open_count = 0;
   end

   always @(posedge clock) begin
      glyph_read_type want;
      if (reset) begin
         table_small  = BASE_SMALL_RST;
         table_medium = BASE_MEDIUM_RST;
         table_large  = BASE_LARGE_RST;
         pending_reads.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_SMALL:  table_small  = csr_wdata;
               CSR_BASE_MEDIUM: table_medium = csr_wdata;
               CSR_BASE_LARGE:  table_large  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reads.size() == 0) begin
               errors++;
               $display("%0t unexpected result beat: action %0d addr %h count %0d",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]);
            end else begin
               want = pending_reads.pop_front();
               if (rsp_tuser != want.act || rsp_tdata[31:0] != want.addr ||
                   rsp_tdata[39:32] != want.count) begin
                  errors++;
                  $display({"%0t result mismatch: expected action %0d addr %h count %0d,",
                            " got action %0d addr %h count %0d"},
                           $time, want.act, want.addr, want.count,
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32]);
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_reads.push_back(predict_glyph_read(char_type'(req_tdata)));
      end
      open_count = pending_reads.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives characters and table base writes into the GBK glyph address block
// with random idling on both channels; a checker beside the block predicts
// and compares every result beat, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench import ggfa_pkg::*;;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = 40'd0;   // lead, second, third, fourth, font_height
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [39:0]       rsp_tdata;           // rom_address[31:0], byte_count[39:32]
   logic [1:0]        rsp_tuser;           // action
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = 2'd0;
   logic [BASE_W-1:0] csr_wdata = '0;
   int                errors;
   int                open_count;
   bit                idle_on = 1'b1;

   gbk_glyph_flash_address dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   glyph_address_check check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .open_count(open_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("** gbk_glyph_flash_address: FAILED **");
      $finish;
   end

   // result side: random stall bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 12)) @(posedge clock);
      end
   end

   task automatic send_char(input bit [7:0] lead, input bit [7:0] second,
                            input bit [7:0] third, input bit [7:0] fourth,
                            input bit [7:0] hgt);
      char_type ch;
      ch.lead_byte   = lead;
      ch.second_byte = second;
      ch.third_byte  = third;
      ch.fourth_byte = fourth;
      ch.font_height = hgt;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // hold the request side until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_bases(input bit [BASE_W-1:0] small_base,
                             input bit [BASE_W-1:0] mid_base,
                             input bit [BASE_W-1:0] big_base);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE_SMALL;
      csr_wdata <= small_base;
      @(posedge clock);
      csr_index <= CSR_BASE_MEDIUM;
      csr_wdata <= mid_base;
      @(posedge clock);
      csr_index <= CSR_BASE_LARGE;
      csr_wdata <= big_base;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_chars(input int count);
      bit [7:0] lead;
      bit [7:0] second;
      bit [7:0] hgt;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0: lead = 8'($urandom_range(8'hA0, 8'hAB));
            1: lead = 8'($urandom_range(8'hB0, 8'hF7));
            2: lead = 8'($urandom_range(8'h81, 8'hA0));
            3: lead = 8'($urandom_range(8'hAA, 8'hFF));
            4: lead = 8'($urandom_range(8'h81, 8'h82));
            default: lead = 8'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: second = 8'($urandom_range(8'h30, 8'h39));
            1: second = 8'($urandom_range(8'h40, 8'hA0));
            2: second = 8'($urandom_range(8'hA1, 8'hFF));
            default: second = 8'($urandom);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: hgt = HEIGHT_SMALL;
            3, 4, 5: hgt = HEIGHT_MEDIUM;
            6, 7, 8: hgt = HEIGHT_LARGE;
            default: hgt = 8'($urandom);
         endcase
         send_char(lead, second, 8'($urandom), 8'($urandom), hgt);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unsupported heights
      send_char(8'hB0, 8'hA1, 8'h00, 8'h00, 8'd0);
      send_char(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);
      send_char(8'hB0, 8'hA1, 8'h81, 8'h30, 8'd13);
      // trail gap gives a blank fill
      send_char(8'hB0, 8'h7F, 8'h00, 8'h00, HEIGHT_SMALL);
      send_char(8'h82, 8'h7F, 8'h81, 8'h30, HEIGHT_MEDIUM);
      send_char(8'hFF, 8'h7F, 8'hFF, 8'hFF, HEIGHT_LARGE);
      // symbols, including the size-16 lead below the usual start
      send_char(8'hA1, 8'hA1, 8'h00, 8'h00, HEIGHT_SMALL);
      send_char(8'hA0, 8'hA1, 8'h00, 8'h00, HEIGHT_MEDIUM);
      send_char(8'hAB, 8'hFF, 8'h00, 8'h00, HEIGHT_LARGE);
      send_char(8'hA8, 8'hFE, 8'h00, 8'h00, HEIGHT_LARGE);
      // GBK/5 with and without the trail adjust
      send_char(8'hA8, 8'h40, 8'h00, 8'h00, HEIGHT_SMALL);
      send_char(8'hA9, 8'hA0, 8'h00, 8'h00, HEIGHT_MEDIUM);
      // hanzi
      send_char(8'hB0, 8'hA1, 8'h00, 8'h00, HEIGHT_MEDIUM);
      send_char(8'hF7, 8'hFE, 8'h00, 8'h00, HEIGHT_LARGE);
      // GBK/3
      send_char(8'h81, 8'h40, 8'h00, 8'h00, HEIGHT_SMALL);
      send_char(8'hA0, 8'hFF, 8'h00, 8'h00, HEIGHT_LARGE);
      // GBK/4, with a low trail that wraps negative
      send_char(8'hAA, 8'h40, 8'h00, 8'h00, HEIGHT_MEDIUM);
      send_char(8'hFE, 8'hA0, 8'h00, 8'h00, HEIGHT_SMALL);
      send_char(8'hFF, 8'h00, 8'h00, 8'h00, HEIGHT_LARGE);
      // four-byte regions, on and off at height 12
      send_char(8'h81, 8'h39, 8'hEE, 8'h39, HEIGHT_MEDIUM);
      send_char(8'h81, 8'h39, 8'h00, 8'hFF, HEIGHT_LARGE);
      send_char(8'h82, 8'h30, 8'h81, 8'h30, HEIGHT_LARGE);
      send_char(8'h82, 8'hFF, 8'hFF, 8'hFF, HEIGHT_MEDIUM);
      send_char(8'h82, 8'h30, 8'h81, 8'h30, HEIGHT_SMALL);
      // no region
      send_char(8'h00, 8'h00, 8'h00, 8'h00, HEIGHT_MEDIUM);
      drain_results();

      load_bases(24'h000000, 24'h000000, 24'h000000);
      send_random_chars(250);
      drain_results();

      load_bases(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_random_chars(250);
      drain_results();

      load_bases(24'($urandom), 24'($urandom), 24'($urandom));
      send_random_chars(250);
      drain_results();

      idle_on = 1'b0;
      load_bases(BASE_SMALL_RST, 24'($urandom), 24'hFFFFFF);
      send_random_chars(250);
      drain_results();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("** gbk_glyph_flash_address: PASSED **");
      else
         $display("** gbk_glyph_flash_address: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/ggfa_pkg.sv
rtl/core/ggfa_index.sv
rtl/core/gbk_glyph_flash_address.sv
tb/sv/glyph_address_check.sv
tb/sv/testbench.sv
